/* sv/sha_pkg.sv */
// sha-256 byte stream hasher package: beat types, constants, a rotate-right helper
// no dependencies
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_ADD   = 6'b001000,
    ST_PAD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenSlot = 6'd55;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* sv/sha256_byte_stream_hasher.sv */
// a byte that does not fill a block is just stored in ST_IDLE; a byte that fills one
// starts ST_LOAD of the 16 words, then ST_ROUND, then the chain add in ST_ADD; end beat:
// ST_PAD, then one or two padded blocks compressed the same way, then 8 digest beats
// no byte is taken while a block is being compressed by the single round unit
// reset (async, active low) restores the initial hash value, clears counts
// top level: sha-256 hasher fed one byte per beat; uses sha_pkg
module sha256_byte_stream_hasher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha_pkg::out_beat_t out_data_o
);
  import sha_pkg::*;

  state_e      state_q, state_d;
  logic [31:0] buf_q [16];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [63:0] total_q;
  logic [31:0] w_q [16];
  logic [31:0] r_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  cnt_q;   // load word / round index
  logic        final_q; // compressing a padded block
  logic        second_q; // length goes in a second block
  logic [2:0]  oidx_q;

  logic [31:0] w_new, t1, t2, bw;
  logic [31:0] pad_w [16];
  logic [63:0] len_w;

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_data_o.digest_word = h_q[oidx_q];
  assign out_data_o.word_index  = oidx_q;
  assign out_data_o.last_word   = (oidx_q == 3'd7);

  always_comb begin
    bw = buf_q[cnt_q[3:0]];
    w_new = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_new + w_q[9] + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[0];
    t1 = r_q[7] + (rotr(r_q[4], 6) ^ rotr(r_q[4], 11) ^ rotr(r_q[4], 25))
       + ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6])) + K[cnt_q] + w_q[0];
    t2 = (rotr(r_q[0], 2) ^ rotr(r_q[0], 13) ^ rotr(r_q[0], 22))
       + ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]));
  end

  // padded block: 0x80 at the fill point, zeros after, length in the last two words if fill <= 55
  always_comb begin
    len_w = bits_q + {55'd0, fill_q, 3'd0};
    for (int j = 0; j < 16; j++) begin
      for (int b = 0; b < 4; b++) begin
        if (6'(4 * j + b) == fill_q) pad_w[j][31 - 8 * b -: 8] = PadByte;
        else if (6'(4 * j + b) > fill_q) pad_w[j][31 - 8 * b -: 8] = 8'd0;
        else pad_w[j][31 - 8 * b -: 8] = buf_q[j][31 - 8 * b -: 8];
      end
    end
    if (fill_q <= LenSlot) begin
      pad_w[14] = len_w[63:32];
      pad_w[15] = len_w[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.byte_present && fill_q == 6'd63) state_d = ST_LOAD;
          else if (in_data_i.end_of_message) state_d = ST_PAD;
        end
      end
      ST_PAD:   state_d = ST_LOAD;
      ST_LOAD:  if (cnt_q == 6'd15) state_d = ST_ROUND;
      ST_ROUND: if (cnt_q == 6'd63) state_d = ST_ADD;
      ST_ADD: begin
        if (second_q) state_d = ST_LOAD;
        else if (final_q) state_d = ST_OUT;
        else if (total_q[0]) state_d = ST_PAD;
        else state_d = ST_IDLE;
      end
      ST_OUT:   if (out_ready_i && oidx_q == 3'd7) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // window holds w[i..i+15] at w_q[0..15]; shifts each load or round cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0;
      bits_q <= '0;
      cnt_q <= '0;
      final_q <= 1'b0;
      second_q <= 1'b0;
      oidx_q <= '0;
      total_q <= '0;
      for (int k = 0; k < 8; k++) h_q[k] <= IV[k];
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          for (int k = 0; k < 8; k++) r_q[k] <= h_q[k];
          if (in_valid_i) begin
            total_q[0] <= in_data_i.end_of_message; // end pending after full block
            final_q <= 1'b0;
            second_q <= 1'b0;
            if (in_data_i.byte_present) begin
              buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= in_data_i.data_byte;
              fill_q <= fill_q + 6'd1;
              if (fill_q == 6'd63) bits_q <= bits_q + 64'd512;
            end
          end
        end
        ST_PAD: begin
          total_q <= len_w;
          for (int j = 0; j < 16; j++) buf_q[j] <= pad_w[j];
          final_q <= 1'b1;
          second_q <= (fill_q > LenSlot);
          cnt_q <= '0;
          for (int k = 0; k < 8; k++) r_q[k] <= h_q[k];
        end
        ST_LOAD: begin
          for (int k = 0; k < 15; k++) w_q[k] <= w_q[k + 1];
          w_q[15] <= bw;
          cnt_q <= (cnt_q == 6'd15) ? 6'd0 : cnt_q + 6'd1;
        end
        ST_ROUND: begin
          for (int k = 0; k < 15; k++) w_q[k] <= w_q[k + 1];
          w_q[15] <= w_new;
          r_q[7] <= r_q[6]; r_q[6] <= r_q[5]; r_q[5] <= r_q[4];
          r_q[4] <= r_q[3] + t1;
          r_q[3] <= r_q[2]; r_q[2] <= r_q[1]; r_q[1] <= r_q[0];
          r_q[0] <= t1 + t2;
          cnt_q <= cnt_q + 6'd1;
        end
        ST_ADD: begin
          cnt_q <= '0;
          for (int k = 0; k < 8; k++) begin
            h_q[k] <= h_q[k] + r_q[k];
            r_q[k] <= h_q[k] + r_q[k];
          end
          if (second_q) begin
            second_q <= 1'b0;
            for (int k = 0; k < 14; k++) buf_q[k] <= '0;
            buf_q[14] <= total_q[63:32];
            buf_q[15] <= total_q[31:0];
          end
          oidx_q <= '0;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              for (int k = 0; k < 8; k++) h_q[k] <= IV[k];
              fill_q <= '0;
              bits_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/sha_checker.sv */
// port-level checks for the sha-256 hasher, bound to the top level
// uses sha_pkg
module sha_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sha_pkg::out_beat_t out_data_o
);
  import sha_pkg::*;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while digest pending");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_word |=>
      out_valid_o && out_data_o.word_index == $past(out_data_o.word_index) + 3'd1)
    else $error("digest beat skipped");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last_word |=> !out_valid_o)
    else $error("extra digest beat");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_data_o.word_index == 3'd0)
    else $error("digest does not start at word 0");

endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (.*);

/* tb/sha256_byte_stream_hasher_tb.sv */
// testbench for the sha-256 byte stream hasher: random and directed messages,
// digests predicted in-bench and checked beat by beat; uses sha_pkg
`timescale 1ns / 100ps
module sha256_byte_stream_hasher_tb;
  import sha_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;

  sha256_byte_stream_hasher u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  in_beat_t  pending_beats[$];
  out_beat_t expected_words[$];
  int        mismatch_count;
  bit        stim_done;
  bit        quiet_phase;

  // predictor state
  logic [31:0] hash_state[8];
  logic [7:0]  msg_block[64];
  int          block_fill;
  logic [63:0] hashed_bits;

  localparam logic [31:0] ROUND_K[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] START_HASH[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_msg_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int k = 0; k < 8; k++) v[k] = hash_state[k];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int k = 7; k > 0; k--) v[k] = v[k-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++) hash_state[k] += v[k];
  endtask

  task automatic predict_digest(in_beat_t b);
    logic [63:0] total;
    out_beat_t   o;
    if (b.byte_present) begin
      msg_block[block_fill] = b.data_byte;
      block_fill++;
      if (block_fill == 64) begin
        compress_msg_block();
        hashed_bits += 64'd512;
        block_fill = 0;
      end
    end
    if (!b.end_of_message) return;
    total = hashed_bits + 64'(block_fill * 8);
    msg_block[block_fill] = 8'h80;
    for (int k = block_fill + 1; k < 64; k++) msg_block[k] = 8'h00;
    if (block_fill > 55) begin
      compress_msg_block();
      for (int k = 0; k < 64; k++) msg_block[k] = 8'h00;
    end
    for (int k = 0; k < 8; k++) msg_block[56+k] = total[63-8*k -: 8];
    compress_msg_block();
    for (int k = 0; k < 8; k++) begin
      o.digest_word = hash_state[k];
      o.word_index  = 3'(k);
      o.last_word   = (k == 7);
      expected_words.push_back(o);
    end
    for (int k = 0; k < 8; k++) hash_state[k] = START_HASH[k];
    block_fill  = 0;
    hashed_bits = '0;
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  task automatic add_message(int len, bit empty_end, bit with_idles);
    in_beat_t b;
    for (int i = 0; i < len; i++) begin
      if (with_idles && $urandom_range(0, 19) == 0) begin
        b.data_byte = 8'($urandom); b.byte_present = 0; b.end_of_message = 0;
        pending_beats.push_back(b);
      end
      b.data_byte      = 8'($urandom);
      b.byte_present   = 1;
      b.end_of_message = (i == len - 1) && !empty_end;
      pending_beats.push_back(b);
    end
    if (empty_end || len == 0) begin
      b.data_byte = 8'($urandom); b.byte_present = 0; b.end_of_message = 1;
      pending_beats.push_back(b);
    end
  endtask

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      in_data_i  <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) predict_digest(in_data_i);
      if (pending_beats.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 23)) begin
        in_valid_i <= 1;
        in_data_i  <= pending_beats.pop_front();
      end else begin
        in_valid_i <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected digest beat %h", out_data_o));
        end else begin
          out_beat_t e;
          e = expected_words.pop_front();
          if (out_data_o.digest_word !== e.digest_word)
            report_mismatch($sformatf("word %0d: got %h want %h", e.word_index,
                                      out_data_o.digest_word, e.digest_word));
          if (out_data_o.word_index !== e.word_index)
            report_mismatch($sformatf("word_index got %0d want %0d",
                                      out_data_o.word_index, e.word_index));
          if (out_data_o.last_word !== e.last_word)
            report_mismatch($sformatf("last_word got %0b want %0b",
                                      out_data_o.last_word, e.last_word));
        end
      end
      out_ready_i <= quiet_phase || ($urandom_range(0, 99) >= 23);
    end
  end

  initial begin
    in_beat_t b;
    mismatch_count = 0;
    stim_done      = 0;
    quiet_phase    = 0;
    for (int k = 0; k < 8; k++) hash_state[k] = START_HASH[k];
    for (int k = 0; k < 64; k++) msg_block[k] = 8'h00;
    block_fill  = 0;
    hashed_bits = '0;
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;

    // directed: idle beat, empty message, extreme bytes, padding boundaries
    b.data_byte = 8'hff; b.byte_present = 0; b.end_of_message = 0;
    pending_beats.push_back(b);
    add_message(0, 1, 0);
    b.data_byte = 8'h00; b.byte_present = 1; b.end_of_message = 0;
    pending_beats.push_back(b);
    b.data_byte = 8'hff; b.byte_present = 1; b.end_of_message = 1;
    pending_beats.push_back(b);
    add_message(3, 1, 0);
    add_message(56, 0, 0);
    add_message(64, 0, 0);

    // random short messages
    for (int m = 0; m < 10; m++) begin
      int len;
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 8);
        default: len = $urandom_range(1, 16);
      endcase
      if (m >= 3 && m < 7) quiet_phase = 1;
      else quiet_phase = 0;
      add_message(len, $urandom_range(0, 3) == 0, 1);
      wait (pending_beats.size() < 40);
    end
    quiet_phase = 0;

    wait (pending_beats.size() == 0 && !in_valid_i);
    @(posedge clk_i);
    wait (expected_words.size() == 0);
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
